@@ rtl/core/rcsp_pkg.sv @@
// rcsp_pkg: constants, types and the ramp table function for the
// raised-cosine speed profile block. No dependencies.
package rcsp_pkg;

  localparam int COS_TABLE_ENTRIES_DEF = 256;

  // field widths
  localparam int DIST_W   = 16;
  localparam int ANGLE_W  = 15;
  localparam int SPEED_W  = 12;
  localparam int TURN_W   = 14;
  localparam int RATE_W   = 13;
  localparam int PCT_W    = 7;
  localparam int ROM_W    = 16;
  localparam int SPAN_X_W = 11;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;

  // distance band, 1/16 units
  localparam int DIST_LO   = 160;
  localparam int DIST_HI   = 1600;
  localparam int DIST_SPAN = 1440;
  localparam int SPEED_MIN = 400;
  localparam int SPEED_MAX = 2080;

  // heading band, Q3.12 radians
  localparam int ANG_LO   = 205;
  localparam int ANG_HI   = 2143;
  localparam int ANG_SPAN = 1938;
  localparam int RATE_MIN = 1024;
  localparam int RATE_MAX = 5120;

  localparam int HALF_PI_Q12 = 6434;
  localparam int PI_Q12      = 12868;

  localparam int PCT_FULL    = 100;
  localparam int ROM_FRAC    = 15;
  // rate span is 2^12, so the scaled ramp reduces to a rounded shift
  localparam int RATE_SHIFT  = 3;
  localparam int RECIP_SHIFT = 32;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_FIX_SPEED = 1'b0;

  // odd sine polynomial, Q30
  localparam logic [63:0] SIN_C1 = 64'd1686629713;
  localparam logic [63:0] SIN_C3 = 64'd693598668;
  localparam logic [63:0] SIN_C5 = 64'd85569306;
  localparam logic [63:0] SIN_C7 = 64'd5026995;
  localparam logic [63:0] SIN_C9 = 64'd172272;

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_MIN  = 2'd1,
    CLS_MAX  = 2'd2,
    CLS_RAMP = 2'd3
  } ramp_cls_t;

  typedef struct packed {
    ramp_cls_t                   spd_cls;
    ramp_cls_t                   rate_cls;
    logic signed [ANGLE_W-1:0]   heading;
  } prof_side_t;

  // load enables for a module holding two pipeline ranks
  typedef struct packed {
    logic early;
    logic late;
  } stage_en_t;

  // numerator width of the table index division for a given span
  function automatic int num_w(input int span, input int entries);
    return $clog2(span * (entries - 1) + (span >> 1) + 1);
  endfunction

  // (1 - cos(pi x)) / 2 in Q15 as sin^2(pi/2 x), x in Q30
  function automatic logic [ROM_W-1:0] ramp_from_x(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] sq;
    x2 = (x * x) >> 30;
    p  = SIN_C9;
    p  = SIN_C7 - ((x2 * p) >> 30);
    p  = SIN_C5 - ((x2 * p) >> 30);
    p  = SIN_C3 - ((x2 * p) >> 30);
    p  = SIN_C1 - ((x2 * p) >> 30);
    s  = (x * p) >> 30;
    if (s > (64'd1 << 30)) begin
      s = 64'd1 << 30;
    end
    sq = (s * s + (64'd1 << 44)) >> 45;
    return sq[ROM_W-1:0];
  endfunction

endpackage

@@ rtl/core/raised_cosine_speed_profile.sv @@
// raised_cosine_speed_profile: top level, handshake control, sideband
// pipeline and configuration register. Uses rcsp_pkg and all rcsp modules.
//
// One command beat per clock is accepted while the output side does not
// stall, and each gives one result beat. The heading register is
// updated in the input rank at the cycle of acceptance, so a command can
// follow its predecessor in the very next cycle. After the
// input rank come classification, a reciprocal multiply and a correction
// step that turn distance and heading into ramp table indices, a read of the
// raised-cosine table (COS_TABLE_ENTRIES entries, built at elaboration) and
// the final scaling into the result register. Every rank stalls only when
// the one after it is full and stalled, so a waiting result does not stop
// new commands from entering. fix_speed_percent is written over the APB
// port at byte address 0 and should be changed only while no command is in
// flight.
module raised_cosine_speed_profile import rcsp_pkg::*; #(
  parameter int COS_TABLE_ENTRIES = COS_TABLE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // distance [15:0], motion_angle [30:16], forward [31]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // speed [11:0], turn_rate [25:12], heading [40:26], zero [47:41]
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int NS_W = num_w(DIST_SPAN, COS_TABLE_ENTRIES);
  localparam int NA_W = num_w(ANG_SPAN, COS_TABLE_ENTRIES);
  localparam int K_W  = $clog2(COS_TABLE_ENTRIES);

  logic v_a_r, v_b_r, v_c_r, v_d_r, v_e_r, out_valid_r;
  logic en_a, en_b, en_c, en_d, en_e, en_f;
  logic in_beat;

  logic signed [ANGLE_W-1:0] heading_state;
  prof_side_t                side_b;
  prof_side_t                side_c_r;
  prof_side_t                side_d_r;
  logic [NS_W-1:0]           num_spd;
  logic [NA_W-1:0]           num_rate;
  logic [K_W-1:0]            k_spd;
  logic [K_W-1:0]            k_rate;
  logic [SPEED_W-1:0]        speed;
  logic signed [TURN_W-1:0]  turn_rate;
  logic signed [ANGLE_W-1:0] heading;
  logic [PCT_W-1:0]          fix_pct_r;
  logic                      cfg_wr;

  // a rank loads when it is empty or the rank after it moves on
  assign en_f = !out_valid_r || out_tready;
  assign en_e = !v_e_r || en_f;
  assign en_d = !v_d_r || en_e;
  assign en_c = !v_c_r || en_d;
  assign en_b = !v_b_r || en_c;
  assign en_a = !v_a_r || en_b;

  assign in_tready = en_a;
  assign in_beat   = in_tvalid && en_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r       <= 1'b0;
      v_b_r       <= 1'b0;
      v_c_r       <= 1'b0;
      v_d_r       <= 1'b0;
      v_e_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_a) v_a_r <= in_tvalid;
      if (en_b) v_b_r <= v_a_r;
      if (en_c) v_c_r <= v_b_r;
      if (en_d) v_d_r <= v_c_r;
      if (en_e) v_e_r <= v_d_r;
      if (en_f) out_valid_r <= v_e_r;
    end
  end

  rcsp_cmd_stage #(
    .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES),
    .NS_W              (NS_W),
    .NA_W              (NA_W)
  ) u_cmd (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_load       (in_beat),
    .en_a          (en_a),
    .en_b          (en_b),
    .dist_in       (in_tdata[DIST_W-1:0]),
    .angle_in      ($signed(in_tdata[DIST_W +: ANGLE_W])),
    .fwd_in        (in_tdata[DIST_W + ANGLE_W]),
    .heading_state (heading_state),
    .side_b        (side_b),
    .num_spd       (num_spd),
    .num_rate      (num_rate)
  );

  rcsp_const_div #(
    .DIVISOR (DIST_SPAN),
    .N_W     (NS_W),
    .Q_W     (K_W)
  ) u_div_spd (
    .clk  (clk),
    .en   ('{early: en_c, late: en_d}),
    .num  (num_spd),
    .quot (k_spd)
  );

  rcsp_const_div #(
    .DIVISOR (ANG_SPAN),
    .N_W     (NA_W),
    .Q_W     (K_W)
  ) u_div_rate (
    .clk  (clk),
    .en   ('{early: en_c, late: en_d}),
    .num  (num_rate),
    .quot (k_rate)
  );

  // sideband follows the divider ranks
  always_ff @(posedge clk) begin
    if (en_c) side_c_r <= side_b;
    if (en_d) side_d_r <= side_c_r;
  end

  rcsp_profile_out #(
    .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES),
    .K_W               (K_W)
  ) u_out (
    .clk       (clk),
    .en        ('{early: en_e, late: en_f}),
    .k_spd     (k_spd),
    .k_rate    (k_rate),
    .side_d    (side_d_r),
    .fix_pct   (fix_pct_r),
    .speed     (speed),
    .turn_rate (turn_rate),
    .heading   (heading)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - SPEED_W - TURN_W - ANGLE_W)'(0),
                       heading, turn_rate, speed};

  // configuration register
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                  && (cfg_paddr[CFG_ADDR_W-1:2] == REG_FIX_SPEED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fix_pct_r <= '0;
    end else if (cfg_wr) begin
      fix_pct_r <= cfg_pwdata[PCT_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:2] == REG_FIX_SPEED)
                      ? CFG_DATA_W'(fix_pct_r) : '0;

  // a command with zero distance leaves the heading alone
  a_zero_dist_keeps_heading: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[DIST_W-1:0] == '0) |=> $stable(heading_state))
    else $error("heading changed on a zero-distance command");

  // a write to the override register is visible in the cycle after it
  a_cfg_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite
      && (cfg_paddr[CFG_ADDR_W-1:2] == REG_FIX_SPEED)
    |=> fix_pct_r == $past(cfg_pwdata[PCT_W-1:0]))
    else $error("override register not updated by write");

  // a taken result with nothing behind it leaves the output empty
  a_no_phantom_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !v_e_r |=> !out_tvalid)
    else $error("result beat appeared with no command behind it");

endmodule

@@ rtl/core/rcsp_cmd_stage.sv @@
// rcsp_cmd_stage: input rank with the heading state and backward fold,
// then band classification and table index numerators. Uses rcsp_pkg.
module rcsp_cmd_stage import rcsp_pkg::*; #(
  parameter int COS_TABLE_ENTRIES = COS_TABLE_ENTRIES_DEF,
  parameter int NS_W = num_w(DIST_SPAN, COS_TABLE_ENTRIES),
  parameter int NA_W = num_w(ANG_SPAN, COS_TABLE_ENTRIES)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_load,
  input  logic                      en_a,
  input  logic                      en_b,
  input  logic [DIST_W-1:0]         dist_in,
  input  logic signed [ANGLE_W-1:0] angle_in,
  input  logic                      fwd_in,
  output logic signed [ANGLE_W-1:0] heading_state,
  output prof_side_t                side_b,
  output logic [NS_W-1:0]           num_spd,
  output logic [NA_W-1:0]           num_rate
);

  localparam int LAST = COS_TABLE_ENTRIES - 1;

  logic [DIST_W-1:0]         dist_a_r;
  logic signed [ANGLE_W-1:0] head_r;
  logic signed [ANGLE_W-1:0] head_nxt;
  logic signed [ANGLE_W-1:0] fold;
  logic [ANGLE_W-1:0]        mag;
  logic [SPAN_X_W-1:0]       x_spd;
  logic [SPAN_X_W-1:0]       x_ang;
  prof_side_t                side_nxt;
  logic [NS_W-1:0]           num_spd_nxt;
  logic [NA_W-1:0]           num_rate_nxt;
  prof_side_t                side_b_r;
  logic [NS_W-1:0]           num_spd_r;
  logic [NA_W-1:0]           num_rate_r;

  // reverse motion folds the angle into plus or minus half pi
  always_comb begin
    fold = angle_in;
    if (!fwd_in) begin
      if (angle_in >= HALF_PI_Q12) begin
        fold = ANGLE_W'(angle_in - PI_Q12);
      end else if (angle_in <= -HALF_PI_Q12) begin
        fold = ANGLE_W'(angle_in + PI_Q12);
      end
    end
    head_nxt = (dist_in != '0) ? fold : head_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else if (in_load) begin
      head_r <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      dist_a_r <= dist_in;
    end
  end

  assign mag   = head_r[ANGLE_W-1] ? ANGLE_W'(-head_r) : ANGLE_W'(head_r);
  assign x_spd = SPAN_X_W'(dist_a_r - DIST_W'(DIST_LO));
  assign x_ang = SPAN_X_W'(mag - ANGLE_W'(ANG_LO));

  always_comb begin
    side_nxt.heading = head_r;
    if (dist_a_r == '0) begin
      side_nxt.spd_cls = CLS_ZERO;
    end else if (dist_a_r > DIST_W'(DIST_HI)) begin
      side_nxt.spd_cls = CLS_MAX;
    end else if (dist_a_r < DIST_W'(DIST_LO)) begin
      side_nxt.spd_cls = CLS_MIN;
    end else begin
      side_nxt.spd_cls = CLS_RAMP;
    end
    if (mag == '0) begin
      side_nxt.rate_cls = CLS_ZERO;
    end else if (mag > ANGLE_W'(ANG_HI)) begin
      side_nxt.rate_cls = CLS_MAX;
    end else if (mag < ANGLE_W'(ANG_LO)) begin
      side_nxt.rate_cls = CLS_MIN;
    end else begin
      side_nxt.rate_cls = CLS_RAMP;
    end
    num_spd_nxt  = NS_W'(x_spd) * NS_W'(LAST) + NS_W'(DIST_SPAN / 2);
    num_rate_nxt = NA_W'(x_ang) * NA_W'(LAST) + NA_W'(ANG_SPAN / 2);
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      side_b_r   <= side_nxt;
      num_spd_r  <= num_spd_nxt;
      num_rate_r <= num_rate_nxt;
    end
  end

  assign heading_state = head_r;
  assign side_b        = side_b_r;
  assign num_spd       = num_spd_r;
  assign num_rate      = num_rate_r;

endmodule

@@ rtl/core/rcsp_const_div.sv @@
// rcsp_const_div: two-rank division by a constant, reciprocal multiply
// then one compare-and-correct step. Uses rcsp_pkg.
module rcsp_const_div import rcsp_pkg::*; #(
  parameter int DIVISOR = DIST_SPAN,
  parameter int N_W     = num_w(DIST_SPAN, COS_TABLE_ENTRIES_DEF),
  parameter int Q_W     = $clog2(COS_TABLE_ENTRIES_DEF)
) (
  input  logic           clk,
  input  stage_en_t      en,
  input  logic [N_W-1:0] num,
  output logic [Q_W-1:0] quot
);

  localparam logic [63:0] RECIP = (64'd1 << RECIP_SHIFT) / DIVISOR;
  localparam int M_W    = $clog2(RECIP + 1);
  localparam int PROD_W = N_W + M_W;

  logic [PROD_W-1:0] prod_r;
  logic [N_W-1:0]    num_c_r;
  logic [Q_W-1:0]    q0;
  logic [N_W-1:0]    qd;
  logic [N_W-1:0]    rem;
  logic [Q_W-1:0]    quot_nxt;
  logic [Q_W-1:0]    quot_r;

  always_ff @(posedge clk) begin
    if (en.early) begin
      prod_r  <= PROD_W'(num) * PROD_W'(RECIP);
      num_c_r <= num;
    end
  end

  // the estimate is low by at most one
  assign q0       = Q_W'(prod_r >> RECIP_SHIFT);
  assign qd       = N_W'(q0) * N_W'(DIVISOR);
  assign rem      = num_c_r - qd;
  assign quot_nxt = (rem >= N_W'(DIVISOR)) ? q0 + Q_W'(1) : q0;

  always_ff @(posedge clk) begin
    if (en.late) begin
      quot_r <= quot_nxt;
    end
  end

  assign quot = quot_r;

endmodule

@@ rtl/core/rcsp_profile_out.sv @@
// rcsp_profile_out: ramp table read, scaling, override and sign, ending in
// the result register. Uses rcsp_pkg (ramp_from_x builds the table).
module rcsp_profile_out import rcsp_pkg::*; #(
  parameter int COS_TABLE_ENTRIES = COS_TABLE_ENTRIES_DEF,
  parameter int K_W = $clog2(COS_TABLE_ENTRIES)
) (
  input  logic                      clk,
  input  stage_en_t                 en,
  input  logic [K_W-1:0]            k_spd,
  input  logic [K_W-1:0]            k_rate,
  input  prof_side_t                side_d,
  input  logic [PCT_W-1:0]          fix_pct,
  output logic [SPEED_W-1:0]        speed,
  output logic signed [TURN_W-1:0]  turn_rate,
  output logic signed [ANGLE_W-1:0] heading
);

  localparam int LAST = COS_TABLE_ENTRIES - 1;
  localparam logic [63:0] LAST_DIV = 64'(LAST);
  localparam int OVR_ENTRIES = 1 << PCT_W;
  localparam int SPD_PROD_W  = ROM_W + SPAN_X_W;

  logic [ROM_W-1:0]   ramp_rom [COS_TABLE_ENTRIES];
  logic [SPEED_W-1:0] ovr_rom  [OVR_ENTRIES];

  for (genvar g = 0; g < COS_TABLE_ENTRIES; g++) begin : g_ramp
    localparam logic [63:0] XQ = (64'(g) << 30) / LAST_DIV;
    localparam logic [ROM_W-1:0] RVAL = ramp_from_x(XQ);
    assign ramp_rom[g] = RVAL;
  end

  // percents above full scale count as full scale
  for (genvar g = 0; g < OVR_ENTRIES; g++) begin : g_ovr
    localparam int PC = (g > PCT_FULL) ? PCT_FULL : g;
    localparam logic [SPEED_W-1:0] OVAL =
      SPEED_W'((PC * SPEED_MAX + PCT_FULL / 2) / PCT_FULL);
    assign ovr_rom[g] = OVAL;
  end

  logic [ROM_W-1:0]          r_spd_r;
  logic [ROM_W-1:0]          r_rate_r;
  prof_side_t                side_e_r;
  logic [SPD_PROD_W-1:0]     spd_prod;
  logic [SPEED_W-1:0]        spd_ramp;
  logic [ROM_W:0]            rate_sum;
  logic [RATE_W-1:0]         rate_ramp;
  logic [SPEED_W-1:0]        speed_nxt;
  logic [RATE_W-1:0]         rate;
  logic signed [TURN_W-1:0]  turn_nxt;
  logic [SPEED_W-1:0]        speed_r;
  logic signed [TURN_W-1:0]  turn_r;
  logic signed [ANGLE_W-1:0] heading_r;

  always_ff @(posedge clk) begin
    if (en.early) begin
      r_spd_r  <= ramp_rom[k_spd];
      r_rate_r <= ramp_rom[k_rate];
      side_e_r <= side_d;
    end
  end

  assign spd_prod  = SPD_PROD_W'(r_spd_r) * SPD_PROD_W'(SPEED_MAX - SPEED_MIN)
                   + SPD_PROD_W'(1 << (ROM_FRAC - 1));
  assign spd_ramp  = SPEED_W'(SPEED_MIN) + SPEED_W'(spd_prod >> ROM_FRAC);
  assign rate_sum  = {1'b0, r_rate_r} + (ROM_W + 1)'(1 << (RATE_SHIFT - 1));
  assign rate_ramp = RATE_W'(RATE_MIN) + RATE_W'(rate_sum >> RATE_SHIFT);

  always_comb begin
    case (side_e_r.spd_cls)
      CLS_ZERO: speed_nxt = '0;
      CLS_MIN:  speed_nxt = SPEED_W'(SPEED_MIN);
      CLS_MAX:  speed_nxt = SPEED_W'(SPEED_MAX);
      CLS_RAMP: speed_nxt = spd_ramp;
      default:  speed_nxt = '0;
    endcase
    if (side_e_r.spd_cls != CLS_ZERO && fix_pct != '0) begin
      speed_nxt = ovr_rom[fix_pct];
    end
    case (side_e_r.rate_cls)
      CLS_ZERO: rate = '0;
      CLS_MIN:  rate = RATE_W'(RATE_MIN);
      CLS_MAX:  rate = RATE_W'(RATE_MAX);
      CLS_RAMP: rate = rate_ramp;
      default:  rate = '0;
    endcase
    turn_nxt = side_e_r.heading[ANGLE_W-1] ? -TURN_W'(rate) : TURN_W'(rate);
  end

  always_ff @(posedge clk) begin
    if (en.late) begin
      speed_r   <= speed_nxt;
      turn_r    <= turn_nxt;
      heading_r <= side_e_r.heading;
    end
  end

  assign speed     = speed_r;
  assign turn_rate = turn_r;
  assign heading   = heading_r;

endmodule

@@ tb/testbench.sv @@
// testbench: self-checking bench for raised_cosine_speed_profile, covering the speed
// ramp, the turn-rate ramp, the backward heading fold and the speed override
// depends on rcsp_pkg and the raised_cosine_speed_profile rtl
module testbench;

  localparam int ROM_ENTRIES = 256;
  localparam int DW = rcsp_pkg::DIST_W;
  localparam int AW = rcsp_pkg::ANGLE_W;
  localparam int SW = rcsp_pkg::SPEED_W;
  localparam int TW = rcsp_pkg::TURN_W;
  localparam logic [rcsp_pkg::CFG_ADDR_W-1:0] PCT_ADDR =
    rcsp_pkg::CFG_ADDR_W'(4 * rcsp_pkg::REG_FIX_SPEED);

  localparam int HALF_TURN = 6434;
  localparam int FULL_TURN = 12868;
  localparam int PCT_CAP   = 100;

  // sine polynomial terms, Q30
  localparam longint unsigned POLY1 = 64'd1686629713;
  localparam longint unsigned POLY3 = 64'd693598668;
  localparam longint unsigned POLY5 = 64'd85569306;
  localparam longint unsigned POLY7 = 64'd5026995;
  localparam longint unsigned POLY9 = 64'd172272;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef struct {
    logic [DW-1:0]        distance;
    logic signed [AW-1:0] angle;
    logic                 fwd;
  } cmd_t;

  typedef struct {
    logic [SW-1:0]        speed;
    logic signed [TW-1:0] turn;
    logic signed [AW-1:0] heading;
  } prof_t;

  // pct < 0 leaves the override alone; typed rows carry their own answer
  typedef struct {
    int distance;
    int angle;
    int fwd;
    int pct;
    int typed;
    int speed;
    int turn;
    int heading;
  } dir_row_t;

  dir_row_t dir_rows [23] = '{
    '{0,      1000,   1, -1,  1, 0,    0,     0},
    '{65535,  0,      1, -1,  1, 2080, 0,     0},
    '{1,      12868,  0, -1,  1, 400,  0,     0},
    '{1601,   -12868, 1, -1,  1, 2080, -5120, -12868},
    '{1600,   6434,   0, -1,  0, 0,    0,     0},
    '{160,    -6434,  0, -1,  0, 0,    0,     0},
    '{159,    6433,   0, -1,  1, 400,  5120,  6433},
    '{0,      -3000,  1, -1,  1, 0,    5120,  6433},
    '{880,    205,    1, -1,  0, 0,    0,     0},
    '{800,    -204,   1, -1,  0, 0,    0,     0},
    '{1000,   2143,   1, -1,  0, 0,    0,     0},
    '{1200,   2144,   1, -1,  0, 0,    0,     0},
    '{300,    -1,     1, -1,  0, 0,    0,     0},
    '{65535,  -16384, 0, -1,  1, 2080, -5120, -3516},
    '{2,      16383,  0, -1,  1, 400,  5120,  3515},
    '{200,    16383,  1, -1,  0, 0,    0,     0},
    '{1000,   1174,   1, -1,  0, 0,    0,     0},
    '{5,      0,      1, 100, 1, 2080, 0,     0},
    '{0,      500,    1, -1,  1, 0,    0,     0},
    '{700,    500,    1, 127, 0, 0,    0,     0},
    '{65535,  -500,   0, 1,   0, 0,    0,     0},
    '{1000,   1000,   1, 50,  0, 0,    0,     0},
    '{1000,   -2000,  1, 0,   0, 0,    0,     0}
  };

  logic                              clk;
  logic                              rst_n;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [rcsp_pkg::IN_DATA_W-1:0]    in_tdata;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [rcsp_pkg::OUT_DATA_W-1:0]   out_tdata;
  logic                              cfg_psel;
  logic                              cfg_penable;
  logic                              cfg_pwrite;
  logic [rcsp_pkg::CFG_ADDR_W-1:0]   cfg_paddr;
  logic [rcsp_pkg::CFG_DATA_W-1:0]   cfg_pwdata;
  logic [rcsp_pkg::CFG_DATA_W-1:0]   cfg_prdata;
  logic                              cfg_pready;

  logic signed [AW-1:0] heading_now;
  int unsigned          speed_pct;
  prof_t                pending_profiles [$];
  int                   mismatches;
  int                   send_idle;
  int                   recv_stall;

  raised_cosine_speed_profile #(.COS_TABLE_ENTRIES(ROM_ENTRIES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  // (1 - cos) / 2 ramp entry in Q15, via the squared sine polynomial
  function automatic int unsigned cos_ramp_q15(input int unsigned idx);
    longint unsigned last, x, x2, p, s;
    last = ROM_ENTRIES - 1;
    if (idx > last) idx = int'(last);
    x  = (longint'(idx) << 30) / last;
    x2 = (x * x) >> 30;
    p  = POLY9;
    p  = POLY7 - ((x2 * p) >> 30);
    p  = POLY5 - ((x2 * p) >> 30);
    p  = POLY3 - ((x2 * p) >> 30);
    p  = POLY1 - ((x2 * p) >> 30);
    s  = (x * p) >> 30;
    if (s > ONE_Q30) s = ONE_Q30;
    return int'((s * s + (64'd1 << 44)) >> 45);
  endfunction

  // zero stays zero, flat ends outside the band, raised cosine inside
  function automatic int unsigned ramp_map(input int unsigned v, input int unsigned lo,
                                           input int unsigned hi, input int unsigned base,
                                           input int unsigned top);
    int unsigned idx;
    if (v == 0) return 0;
    if (v > hi) return top;
    if (v < lo) return base;
    idx = ((v - lo) * (ROM_ENTRIES - 1) + (hi - lo) / 2) / (hi - lo);
    return base + (((top - base) * cos_ramp_q15(idx) + 16384) >> 15);
  endfunction

  function automatic void profile_step(input cmd_t c, output prof_t r);
    int a;
    int unsigned spd, rate, mag;
    if (c.distance != 0) begin
      a = c.angle;
      if (!c.fwd) begin
        if (a >= HALF_TURN) a = a - FULL_TURN;
        else if (a <= -HALF_TURN) a = a + FULL_TURN;
      end
      heading_now = AW'(a);
    end
    spd = ramp_map(c.distance, 160, 1600, 400, 2080);
    if (spd != 0 && speed_pct != 0)
      spd = ((speed_pct > PCT_CAP ? PCT_CAP : speed_pct) * 2080 + 50) / 100;
    a = heading_now;
    mag = a < 0 ? -a : a;
    rate = ramp_map(mag, 205, 2143, 1024, 5120);
    r.speed   = SW'(spd);
    r.turn    = TW'(a < 0 ? -int'(rate) : int'(rate));
    r.heading = heading_now;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int a;
    case ($urandom_range(9))
      0:       c.distance = '0;
      1:       c.distance = DW'($urandom_range(159, 1));
      2, 3, 4: c.distance = DW'($urandom_range(1600, 160));
      5:       c.distance = DW'($urandom_range(1620, 1580));
      6:       c.distance = DW'($urandom_range(180, 140));
      7:       c.distance = DW'($urandom_range(65535, 1601));
      default: c.distance = DW'($urandom);
    endcase
    case ($urandom_range(7))
      0:       a = $urandom_range(300);
      1, 2:    a = $urandom_range(2143, 205);
      3:       a = $urandom_range(HALF_TURN + 3, HALF_TURN - 3);
      4:       a = $urandom_range(FULL_TURN, 12000);
      default: a = $urandom_range(16383);
    endcase
    if ($urandom_range(1)) a = -a;
    c.angle = AW'(a);
    c.fwd = 1'($urandom_range(1));
    return c;
  endfunction

  task automatic send_cmd(input cmd_t c, input bit typed, input prof_t typed_res);
    prof_t want;
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {c.fwd, c.angle, c.distance};
    do @(posedge clk); while (!in_tready);
    profile_step(c, want);
    pending_profiles.push_back(typed ? typed_res : want);
    @(negedge clk);
  endtask

  // hold off until the pipeline is empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_profiles.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_speed_pct(input int v);
    settle();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= PCT_ADDR;
    cfg_pwdata  <= rcsp_pkg::CFG_DATA_W'(v);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== rcsp_pkg::CFG_DATA_W'(v & 'h7F)) begin
      mismatches++;
      $display("%0t fix_speed_percent readback: expected %0d, got %0d",
               $time, v & 'h7F, cfg_prdata);
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    speed_pct = v & 'h7F;
  endtask

  always @(negedge clk) begin
    out_tready <= (recv_stall == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    prof_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.speed   = out_tdata[0 +: SW];
      got.turn    = out_tdata[SW +: TW];
      got.heading = out_tdata[SW + TW +: AW];
      if (pending_profiles.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result beat: expected none, got %h", $time, out_tdata);
      end else begin
        want = pending_profiles.pop_front();
        if (got.speed !== want.speed) begin
          mismatches++;
          $display("%0t speed: expected %0d, got %0d", $time, want.speed, got.speed);
        end
        if (got.turn !== want.turn) begin
          mismatches++;
          $display("%0t turn_rate: expected %0d, got %0d", $time, want.turn, got.turn);
        end
        if (got.heading !== want.heading) begin
          mismatches++;
          $display("%0t heading: expected %0d, got %0d", $time, want.heading, got.heading);
        end
      end
    end
  end

  initial begin
    cmd_t  c;
    prof_t typed_res;
    int    seg, n, pct;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    heading_now = '0;
    speed_pct   = 0;
    mismatches  = 0;
    send_idle   = 35;
    recv_stall  = 76;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].pct >= 0) set_speed_pct(dir_rows[i].pct);
      c.distance = DW'(dir_rows[i].distance);
      c.angle    = AW'(dir_rows[i].angle);
      c.fwd      = 1'(dir_rows[i].fwd);
      typed_res.speed   = SW'(dir_rows[i].speed);
      typed_res.turn    = TW'(dir_rows[i].turn);
      typed_res.heading = AW'(dir_rows[i].heading);
      send_cmd(c, dir_rows[i].typed != 0, typed_res);
    end

    // receiver-idle phases, then sender-idle phases, then none
    for (seg = 0; seg < 6; seg++) begin
      case (seg)
        0:       pct = 0;
        1:       pct = 100;
        2:       pct = 127;
        3:       pct = 1;
        4:       pct = $urandom_range(99, 2);
        default: pct = 0;
      endcase
      set_speed_pct(pct);
      send_idle  = seg < 2 ? 35 : (seg < 4 ? 76 : 0);
      recv_stall = seg < 2 ? 76 : (seg < 4 ? 35 : 0);
      for (n = 0; n < 155; n++) begin
        if (n == 60) settle();
        send_cmd(random_cmd(), 1'b0, typed_res);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/rcsp_pkg.sv
rtl/core/rcsp_cmd_stage.sv
rtl/core/rcsp_const_div.sv
rtl/core/rcsp_profile_out.sv
rtl/core/raised_cosine_speed_profile.sv
tb/testbench.sv
